>>> rtl/vwet_pkg.sv
package vwet_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned SQ_W   = 31;   // (2^15)^2 fits in 31 bits unsigned
    localparam int unsigned MAX_DIM = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // compare_mode codes
    localparam logic [1:0] MODE_SIGNED = 2'd0;
    localparam logic [1:0] MODE_ABS    = 2'd1;
    localparam logic [1:0] MODE_LEN    = 2'd2;

    // trigger_options bits
    localparam int unsigned OPT_LEAVE_BIT = 0;
    localparam int unsigned OPT_CONT_BIT  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTS    = 3'd7;

    localparam logic signed [DATA_W-1:0] LOWER_RST = 16'sd0;
    localparam logic signed [DATA_W-1:0] UPPER_RST = 16'sd256;  // 1.0 in Q8.8

    typedef logic signed [DATA_W-1:0] t_q88;

    typedef struct packed {
        logic enable;
        t_q88 obs_x;
        t_q88 obs_y;
        t_q88 obs_z;
        t_q88 send_x;
        t_q88 send_y;
        t_q88 send_z;
    } t_in_beat;

    typedef struct packed {
        logic event_fire;
        logic condition_met;
        t_q88 event_x;
        t_q88 event_y;
        t_q88 event_z;
    } t_out_beat;

    // what one lane found for its component
    typedef struct packed {
        logic            sgn_in;
        logic            sgn_out;
        logic            abs_in;
        logic            abs_out;
        logic [SQ_W-1:0] sq_obs;
        logic [SQ_W-1:0] sq_lo;
        logic [SQ_W-1:0] sq_hi;
    } t_lane_res;

endpackage

>>> rtl/vwet_if.sv
interface vwet_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/vector_window_event_trigger.sv
// Channel | Dir | Modport | Payload
// i_in    | in  | sink    | enable, obs_x/y/z, send_x/y/z (t_in_beat)
// o_out   | out | source  | event_fire, condition_met, event_x/y/z (t_out_beat)
// cfg     | in  | -       | i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// One beat per cycle sustained while the output takes beats.
// Stage one is the lane bank (compares and three 16x16 squares per lane),
// stage two the merge (sums of squares, compare, armed flag) into the output register.
// Sync active-low reset clears valids and the armed flag, presets the config registers.
// A stall at the output holds both stages; the input keeps taking beats while stage one
// is free.
module vector_window_event_trigger #(
    parameter int unsigned DIM = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    vwet_if.sink                             i_in,
    vwet_if.source                           o_out,
    input  logic                             i_cfg_we,
    input  logic [vwet_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vwet_pkg::DATA_W-1:0]      i_cfg_data
);
    import vwet_pkg::*;

    // config registers
    t_q88       r_lower [MAX_DIM];
    t_q88       r_upper [MAX_DIM];
    logic [1:0] r_mode;
    logic [1:0] r_opts;

    // stage one: lane bank plus side band
    logic       r_s1_vld;
    logic       r_s1_en;
    t_q88       r_s1_send_x;
    t_q88       r_s1_send_y;
    t_q88       r_s1_send_z;

    // stage two: output register lives in the merge
    logic       r_out_vld;

    logic       w_out_load;
    logic       w_s1_free;
    logic       w_in_acc;
    t_q88       w_obs [MAX_DIM];
    t_lane_res  w_lane [DIM];
    t_out_beat  w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIM; d++) begin
                r_lower[d] <= LOWER_RST;
                r_upper[d] <= UPPER_RST;
            end
            r_mode <= MODE_SIGNED;
            r_opts <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOWER_X: r_lower[0] <= i_cfg_data;
                CFG_LOWER_Y: r_lower[1] <= i_cfg_data;
                CFG_LOWER_Z: r_lower[2] <= i_cfg_data;
                CFG_UPPER_X: r_upper[0] <= i_cfg_data;
                CFG_UPPER_Y: r_upper[1] <= i_cfg_data;
                CFG_UPPER_Z: r_upper[2] <= i_cfg_data;
                CFG_MODE:    r_mode     <= i_cfg_data[1:0];
                CFG_OPTS:    r_opts     <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake: output register frees on take, stage one frees on move to output
    assign w_out_load = r_s1_vld && (!r_out_vld || o_out.ready);
    assign w_s1_free  = !r_s1_vld || w_out_load;
    assign w_in_acc   = i_in.valid && w_s1_free;
    assign i_in.ready = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_vld <= w_in_acc;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_en     <= i_in.payload.enable;
            r_s1_send_x <= i_in.payload.send_x;
            r_s1_send_y <= i_in.payload.send_y;
            r_s1_send_z <= i_in.payload.send_z;
        end
    end

    assign w_obs[0] = i_in.payload.obs_x;
    assign w_obs[1] = i_in.payload.obs_y;
    assign w_obs[2] = i_in.payload.obs_z;

    // one lane per tested component; components beyond DIM only carry payload
    for (genvar g = 0; g < DIM; g++) begin : g_lane
        vwet_lane u_lane (
            .i_clk  (i_clk),
            .i_load (w_in_acc),
            .i_obs  (w_obs[g]),
            .i_lo   (r_lower[g]),
            .i_hi   (r_upper[g]),
            .o_res  (w_lane[g])
        );
    end

    vwet_merge #(
        .DIM (DIM)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_out_load),
        .i_lane   (w_lane),
        .i_enable (r_s1_en),
        .i_send_x (r_s1_send_x),
        .i_send_y (r_s1_send_y),
        .i_send_z (r_s1_send_z),
        .i_mode   (r_mode),
        .i_opts   (r_opts),
        .o_res    (w_res)
    );

    assign o_out.valid   = r_out_vld;
    assign o_out.payload = w_res;

`ifndef NO_ASSERTIONS
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_vld)
        else $error("accepted beat did not reach stage one");

    a_s1_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_out_load) |=> (r_s1_vld && $stable(r_s1_en)))
        else $error("stage one lost its beat under stall");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_out.valid)
        else $error("merged beat not presented");

    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && !r_s1_en) |=>
            (!o_out.payload.event_fire && !o_out.payload.condition_met))
        else $error("disabled beat reported a condition or event");

    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.payload.event_fire) |->
            ((o_out.payload.event_x == '0) && (o_out.payload.event_y == '0)
             && (o_out.payload.event_z == '0)))
        else $error("payload present without event");
`endif

endmodule

>>> rtl/vwet_lane.sv
module vwet_lane (
    input  logic                i_clk,
    input  logic                i_load,
    input  vwet_pkg::t_q88      i_obs,
    input  vwet_pkg::t_q88      i_lo,
    input  vwet_pkg::t_q88      i_hi,
    output vwet_pkg::t_lane_res o_res
);
    import vwet_pkg::*;

    t_lane_res r_res;
    t_lane_res n_res;

    logic signed [2*DATA_W-1:0] w_p_obs;
    logic signed [2*DATA_W-1:0] w_p_lo;
    logic signed [2*DATA_W-1:0] w_p_hi;
    logic [DATA_W-2:0] w_a_obs;
    logic [DATA_W-2:0] w_a_lo;
    logic [DATA_W-2:0] w_a_hi;

    // saturating magnitude: most negative code maps to the largest positive one
    function automatic logic [DATA_W-2:0] sat_abs(input t_q88 v);
        logic [DATA_W-1:0] neg;
        neg = 16'(-v);
        if (v[DATA_W-1] && (v[DATA_W-2:0] == '0)) begin
            sat_abs = '1;
        end else if (v[DATA_W-1]) begin
            sat_abs = neg[DATA_W-2:0];
        end else begin
            sat_abs = v[DATA_W-2:0];
        end
    endfunction

    always_comb begin
        w_p_obs = i_obs * i_obs;
        w_p_lo  = i_lo * i_lo;
        w_p_hi  = i_hi * i_hi;
        w_a_obs = sat_abs(i_obs);
        w_a_lo  = sat_abs(i_lo);
        w_a_hi  = sat_abs(i_hi);

        n_res.sgn_in  = (i_obs >= i_lo) && (i_obs <= i_hi);
        n_res.sgn_out = (i_obs < i_lo) || (i_obs > i_hi);
        n_res.abs_in  = (w_a_obs >= w_a_lo) && (w_a_obs <= w_a_hi);
        n_res.abs_out = (w_a_obs < w_a_lo) || (w_a_obs > w_a_hi);
        n_res.sq_obs  = w_p_obs[SQ_W-1:0];
        n_res.sq_lo   = w_p_lo[SQ_W-1:0];
        n_res.sq_hi   = w_p_hi[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> rtl/vwet_merge.sv
module vwet_merge #(
    parameter int unsigned DIM = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  vwet_pkg::t_lane_res i_lane [DIM],
    input  logic                i_enable,
    input  vwet_pkg::t_q88      i_send_x,
    input  vwet_pkg::t_q88      i_send_y,
    input  vwet_pkg::t_q88      i_send_z,
    input  logic [1:0]          i_mode,
    input  logic [1:0]          i_opts,
    output vwet_pkg::t_out_beat o_res
);
    import vwet_pkg::*;

    localparam int unsigned SUM_W = SQ_W + $clog2(DIM);

    logic             r_armed;
    logic             n_armed;
    t_out_beat        r_res;
    t_out_beat        n_res;
    logic [SUM_W-1:0] w_so;
    logic [SUM_W-1:0] w_sl;
    logic [SUM_W-1:0] w_sh;
    logic             w_any_sgn_in;
    logic             w_any_sgn_out;
    logic             w_any_abs_in;
    logic             w_any_abs_out;
    logic             w_leave;
    logic             w_cond;
    logic             w_fire;

    always_comb begin
        w_so = '0;
        w_sl = '0;
        w_sh = '0;
        w_any_sgn_in  = 1'b0;
        w_any_sgn_out = 1'b0;
        w_any_abs_in  = 1'b0;
        w_any_abs_out = 1'b0;
        for (int d = 0; d < DIM; d++) begin
            w_so = w_so + SUM_W'(i_lane[d].sq_obs);
            w_sl = w_sl + SUM_W'(i_lane[d].sq_lo);
            w_sh = w_sh + SUM_W'(i_lane[d].sq_hi);
            w_any_sgn_in  = w_any_sgn_in  | i_lane[d].sgn_in;
            w_any_sgn_out = w_any_sgn_out | i_lane[d].sgn_out;
            w_any_abs_in  = w_any_abs_in  | i_lane[d].abs_in;
            w_any_abs_out = w_any_abs_out | i_lane[d].abs_out;
        end

        w_leave = i_opts[OPT_LEAVE_BIT];
        case (i_mode)
            MODE_SIGNED: begin
                w_cond = w_leave ? w_any_sgn_out : w_any_sgn_in;
            end
            MODE_ABS: begin
                w_cond = w_leave ? w_any_abs_out : w_any_abs_in;
            end
            MODE_LEN: begin
                w_cond = w_leave ? ((w_so <= w_sl) || (w_so >= w_sh))
                                 : ((w_so >= w_sl) && (w_so <= w_sh));
            end
            default: begin
                w_cond = 1'b0;
            end
        endcase

        w_fire  = i_enable && w_cond && (!r_armed || i_opts[OPT_CONT_BIT]);
        n_armed = i_enable ? w_cond : r_armed;

        n_res.event_fire    = w_fire;
        n_res.condition_met = i_enable && w_cond;
        n_res.event_x       = w_fire ? i_send_x : '0;
        n_res.event_y       = w_fire ? i_send_y : '0;
        n_res.event_z       = w_fire ? i_send_z : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_load) begin
            r_armed <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vwet_pkg::*;

    localparam int DIM          = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_OFF     = 300;     // long output stall, far deeper than the pipe
    localparam int IDLE_PCT     = 23;
    localparam int SETTLE_CYCS  = 6;       // pipe is two deep; spare margin on top
    localparam int RAND_PHASES  = 16;      // every mode x every option pair
    localparam int PHASE_BEATS  = 64;
    localparam int PRINT_CAP    = 100;

    // mode 3 is left unused by the block: condition must read false
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam logic [1:0] OPTS_ENTER_EDGE = 2'b00;
    localparam logic [1:0] OPTS_LEAVE_EDGE = 2'b01;
    localparam logic [1:0] OPTS_ENTER_CONT = 2'b10;
    localparam logic [1:0] OPTS_LEAVE_CONT = 2'b11;

    typedef struct packed {
        t_q88       lo_x;
        t_q88       lo_y;
        t_q88       lo_z;
        t_q88       hi_x;
        t_q88       hi_y;
        t_q88       hi_z;
        logic [1:0] mode;
        logic [1:0] opts;
    } t_window;

    // one row of the directed table: either a window load or a beat,
    // with the result typed in where it is obvious
    typedef struct packed {
        bit       is_cfg;
        t_window  w;
        t_in_beat beat;
        bit       typed;
        logic     fire;
        logic     cond;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [DATA_W-1:0]     i_cfg_data;

    vwet_if #(.T(t_in_beat))  in_if ();
    vwet_if #(.T(t_out_beat)) out_if ();

    vector_window_event_trigger #(
        .DIM (DIM)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block: window registers as last written, and the armed flag
    t_window   win;
    bit        armed;
    t_out_beat pending_events[$];   // predicted output beats, oldest first
    t_step     directed_plan[$];
    t_in_beat  last_beat;

    int n_fail;
    int cycles;
    int stall_asks;                  // bumped by the sender, served by the receiver
    bit calm;                        // no idling on either side while set

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // magnitude with the most negative code clipped to full scale
    function automatic int q88_mag(int v);
        if (v == -32768) return 32767;
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit window_hit(t_in_beat b);
        int     ov[3];
        int     lv[3];
        int     hv[3];
        longint so;
        longint sl;
        longint sh;
        bit     leave;
        bit     hit;
        ov[0] = b.obs_x;  ov[1] = b.obs_y;  ov[2] = b.obs_z;
        lv[0] = win.lo_x; lv[1] = win.lo_y; lv[2] = win.lo_z;
        hv[0] = win.hi_x; hv[1] = win.hi_y; hv[2] = win.hi_z;
        leave = win.opts[OPT_LEAVE_BIT];
        hit = 1'b0;
        so = 0;
        sl = 0;
        sh = 0;
        for (int d = 0; d < DIM; d++) begin
            // squares on the raw codes, before any folding
            so += longint'(ov[d]) * longint'(ov[d]);
            sl += longint'(lv[d]) * longint'(lv[d]);
            sh += longint'(hv[d]) * longint'(hv[d]);
            if (win.mode == MODE_ABS) begin
                ov[d] = q88_mag(ov[d]);
                lv[d] = q88_mag(lv[d]);
                hv[d] = q88_mag(hv[d]);
            end
            if (leave) hit |= (ov[d] < lv[d]) || (ov[d] > hv[d]);
            else       hit |= (ov[d] >= lv[d]) && (ov[d] <= hv[d]);
        end
        case (win.mode)
            MODE_SIGNED, MODE_ABS: return hit;
            MODE_LEN: begin
                // leave in length mode is inclusive at both bounds
                if (leave) return (so <= sl) || (so >= sh);
                return (so >= sl) && (so <= sh);
            end
            default: return 1'b0;
        endcase
    endfunction

    // output beat for one input beat; moves the armed flag
    function automatic t_out_beat next_event(t_in_beat b);
        t_out_beat r;
        bit        hit;
        r = '0;
        if (!b.enable) return r;   // disabled tick: all zero, flag kept
        hit = window_hit(b);
        r.condition_met = hit;
        r.event_fire    = hit && (!armed || win.opts[OPT_CONT_BIT]);
        armed = hit;
        if (r.event_fire) begin
            r.event_x = b.send_x;
            r.event_y = b.send_y;
            r.event_z = b.send_z;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void plan_window(int lx, int ly, int lz, int hx, int hy, int hz,
                                        logic [1:0] mode, logic [1:0] opts);
        t_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.w.lo_x = t_q88'(lx); s.w.lo_y = t_q88'(ly); s.w.lo_z = t_q88'(lz);
        s.w.hi_x = t_q88'(hx); s.w.hi_y = t_q88'(hy); s.w.hi_z = t_q88'(hz);
        s.w.mode = mode;
        s.w.opts = opts;
        directed_plan.push_back(s);
    endfunction

    // kf/kc of -1: leave the result to the predictor
    function automatic void plan_beat(bit en, int ox, int oy, int oz,
                                      int sx, int sy, int sz, int kf, int kc);
        t_step s;
        s = '0;
        s.beat.enable = en;
        s.beat.obs_x  = t_q88'(ox); s.beat.obs_y  = t_q88'(oy); s.beat.obs_z  = t_q88'(oz);
        s.beat.send_x = t_q88'(sx); s.beat.send_y = t_q88'(sy); s.beat.send_z = t_q88'(sz);
        s.typed = (kf >= 0);
        s.fire  = (kf > 0);
        s.cond  = (kc > 0);
        directed_plan.push_back(s);
    endfunction

    function automatic t_window rand_window(int p);
        t_window w;
        int      lv[3];
        int      hv[3];
        int      c;
        int      wd;
        int      t;
        for (int d = 0; d < 3; d++) begin
            if (p == 5) begin
                lv[d] = -32768;
                hv[d] = 32767;
            end else if (p == 10) begin
                lv[d] = 32767;       // fully inverted: no signed compare can hit
                hv[d] = -32768;
            end else begin
                c  = int'($urandom_range(0, 4000)) - 2000;
                wd = int'($urandom_range(0, 800));
                lv[d] = c - wd;
                hv[d] = c + wd;
                if (p == 14) hv[d] = lv[d];
                else if ($urandom_range(0, 9) == 0) begin
                    t = lv[d]; lv[d] = hv[d]; hv[d] = t;
                end
            end
        end
        w.lo_x = t_q88'(lv[0]); w.lo_y = t_q88'(lv[1]); w.lo_z = t_q88'(lv[2]);
        w.hi_x = t_q88'(hv[0]); w.hi_y = t_q88'(hv[1]); w.hi_z = t_q88'(hv[2]);
        w.mode = 2'(p % 4);
        w.opts = 2'(p / 4);
        return w;
    endfunction

    // observed values cluster on the bounds so both sides of each compare get hit;
    // a quarter of beats repeat the last observation so edge mode sees steady runs
    function automatic t_in_beat rand_beat();
        t_in_beat b;
        int       ov[3];
        int       lv[3];
        int       hv[3];
        int       r;
        lv[0] = win.lo_x; lv[1] = win.lo_y; lv[2] = win.lo_z;
        hv[0] = win.hi_x; hv[1] = win.hi_y; hv[2] = win.hi_z;
        for (int d = 0; d < 3; d++) begin
            r = int'($urandom_range(0, 99));
            if (r < 30)      ov[d] = lv[d] + int'($urandom_range(0, 16)) - 8;
            else if (r < 60) ov[d] = hv[d] + int'($urandom_range(0, 16)) - 8;
            else if (r < 80) ov[d] = int'($urandom_range(0, 3000)) - 1500;
            else if (r < 92) ov[d] = int'(t_q88'($urandom));
            else begin
                case ($urandom_range(0, 3))
                    0:       ov[d] = -32768;
                    1:       ov[d] = 32767;
                    2:       ov[d] = -1;
                    default: ov[d] = 0;
                endcase
            end
            if (win.mode == MODE_ABS && r < 60 && $urandom_range(0, 1) == 1) ov[d] = -ov[d];
        end
        b.enable = ($urandom_range(0, 99) < 88);
        b.obs_x  = t_q88'(ov[0]);
        b.obs_y  = t_q88'(ov[1]);
        b.obs_z  = t_q88'(ov[2]);
        if ($urandom_range(0, 3) == 0) begin
            b.obs_x = last_beat.obs_x;
            b.obs_y = last_beat.obs_y;
            b.obs_z = last_beat.obs_z;
        end
        b.send_x = t_q88'($urandom);
        b.send_y = t_q88'($urandom);
        b.send_z = t_q88'($urandom);
        last_beat = b;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Drive tasks; all called from the single sender process
    // ------------------------------------------------------------------

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        // the block masks mode and options to two bits
        case (idx)
            CFG_LOWER_X: win.lo_x = data;
            CFG_LOWER_Y: win.lo_y = data;
            CFG_LOWER_Z: win.lo_z = data;
            CFG_UPPER_X: win.hi_x = data;
            CFG_UPPER_Y: win.hi_y = data;
            CFG_UPPER_Z: win.hi_z = data;
            CFG_MODE:    win.mode = data[1:0];
            CFG_OPTS:    win.opts = data[1:0];
            default: ;
        endcase
    endtask

    // stop offering, wait for every predicted beat, then let the pipe drain
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCS) @(posedge i_clk);
    endtask

    task automatic load_window(t_window w);
        settle();
        write_reg(CFG_LOWER_X, w.lo_x);
        write_reg(CFG_LOWER_Y, w.lo_y);
        write_reg(CFG_LOWER_Z, w.lo_z);
        write_reg(CFG_UPPER_X, w.hi_x);
        write_reg(CFG_UPPER_Y, w.hi_y);
        write_reg(CFG_UPPER_Z, w.hi_z);
        // junk in the unused upper bits must be dropped
        write_reg(CFG_MODE, {14'($urandom), w.mode});
        write_reg(CFG_OPTS, {14'($urandom), w.opts});
        i_cfg_we <= 1'b0;
    endtask

    task automatic offer_beat(t_in_beat b, bit typed, logic kf, logic kc);
        t_out_beat pred;
        t_out_beat want;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= b;
        do @(posedge i_clk); while (!in_if.ready);
        // beat taken at this edge: predict now, against the window it will see
        pred = next_event(b);
        want = '0;
        if (typed) begin
            want.event_fire    = kf;
            want.condition_met = kc;
            if (kf) begin
                want.event_x = b.send_x;
                want.event_y = b.send_y;
                want.event_z = b.send_z;
            end
        end
        pending_events.push_back(typed ? want : pred);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        if (n_fail < PRINT_CAP)
            $display("%0t ns: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        n_fail++;
    endtask

    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat want;
        got = out_if.payload;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected output beat", 1, 0);
            end else begin
                want = pending_events.pop_front();
                if (got.event_fire !== want.event_fire)
                    report_mismatch("event_fire", got.event_fire, want.event_fire);
                if (got.condition_met !== want.condition_met)
                    report_mismatch("condition_met", got.condition_met, want.condition_met);
                if (got.event_x !== want.event_x)
                    report_mismatch("event_x", got.event_x, want.event_x);
                if (got.event_y !== want.event_y)
                    report_mismatch("event_y", got.event_y, want.event_y);
                if (got.event_z !== want.event_z)
                    report_mismatch("event_z", got.event_z, want.event_z);
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        int stalls_seen;
        hold_left   = 0;
        stalls_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_asks != stalls_seen) begin
                stalls_seen = stall_asks;
                hold_left   = HOLD_OFF;
            end
            if (!i_rst_n) begin
                out_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (calm) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: reset, directed table, random phases, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        n_fail     = 0;
        cycles     = 0;
        stall_asks = 0;
        calm       = 1'b0;
        armed      = 1'b0;
        last_beat  = '0;
        // window as it comes out of reset
        win.lo_x = LOWER_RST; win.lo_y = LOWER_RST; win.lo_z = LOWER_RST;
        win.hi_x = UPPER_RST; win.hi_y = UPPER_RST; win.hi_z = UPPER_RST;
        win.mode = MODE_SIGNED;
        win.opts = OPTS_ENTER_EDGE;

        // reset window [0, 1.0], signed, enter, edge
        plan_beat(1,      0,      0,      0,      1,      2,      3,  1,  1);
        plan_beat(1,      0,      0,      0,      4,      5,      6,  0,  1);  // no re-fire
        plan_beat(0,      0,      0,      0,  32767, -32768,     -1,  0,  0);  // disabled
        plan_beat(1,     -1,    257, -32768,      7,      8,      9,  0,  0);
        plan_beat(1,    256,     -1,     -1,  32767, -32768,     -1,  1,  1);  // upper inclusive
        // full-scale window: leaving it is impossible
        plan_window(-32768, -32768, -32768, 32767, 32767, 32767, MODE_SIGNED, OPTS_LEAVE_CONT);
        plan_beat(1, -32768,  32767,      0,     -1,     -1,     -1,  0,  0);
        // absolute: both bounds fold to full scale, -32768 clips onto it
        plan_window(-32768, -32768, -32768, 32767, 32767, 32767, MODE_ABS, OPTS_ENTER_CONT);
        plan_beat(1, -32768,      0,      0, -32768,      0,  32767,  1,  1);
        plan_beat(1,  32767,      0,      0,     11,     12,     13,  1,  1);
        plan_beat(1, -32767,      0,      0,     14,     15,     16,  1,  1);
        plan_beat(1,  32766, -32766,      0,     17,     18,     19,  0,  0);
        // length: biggest sum of squares exactly on the upper bound
        plan_window(0, 0, 0, -32768, -32768, -32768, MODE_LEN, OPTS_ENTER_EDGE);
        plan_beat(1, -32768, -32768, -32768,    100,    200,    300,  1,  1);
        plan_beat(1,      0,      0,      0,    400,    500,    600,  0,  1);
        plan_window(256, 0, 0, 512, 0, 0, MODE_LEN, OPTS_LEAVE_EDGE);
        plan_beat(1,      0,    256,      0,     21,     22,     23, -1, -1);
        plan_beat(1,    300,      0,      0,     24,     25,     26, -1, -1);
        plan_beat(1,      0,      0,    512,     27,     28,     29, -1, -1);
        plan_window(0, 0, 0, 256, 256, 256, MODE_UNUSED, OPTS_ENTER_CONT);
        plan_beat(1,      0,      0,      0,     31,     32,     33,  0,  0);
        // inverted bounds: empty window, no error
        plan_window(100, 100, 100, -100, -100, -100, MODE_SIGNED, OPTS_ENTER_CONT);
        plan_beat(1,      0,      0,      0,     34,     35,     36,  0,  0);
        plan_beat(1,    100,   -100,     50,     37,     38,     39,  0,  0);
        // only x has a window; flag must survive a disabled tick
        plan_window(-512, 1000, 1000, -256, 900, 900, MODE_SIGNED, OPTS_ENTER_EDGE);
        plan_beat(1,   -300,      0,      0,     41,     42,     43, -1, -1);
        plan_beat(0,   -300,      0,      0,     44,     45,     46,  0,  0);
        plan_beat(1,   -512,      5,      5,     47,     48,     49, -1, -1);
        plan_window(-10, -10, -10, 10, 10, 10, MODE_SIGNED, OPTS_LEAVE_EDGE);
        plan_beat(1,      0,      0,     11,     51,     52,     53, -1, -1);
        plan_beat(1,      0,    -11,      0,     54,     55,     56, -1, -1);
        plan_beat(1,    -10,     10,      0,     57,     58,     59, -1, -1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg)
                load_window(directed_plan[i].w);
            else
                offer_beat(directed_plan[i].beat, directed_plan[i].typed,
                           directed_plan[i].fire, directed_plan[i].cond);
        end

        // random phases: mode steps fastest, so every mode meets every option pair
        for (int p = 0; p < RAND_PHASES; p++) begin
            load_window(rand_window(p));
            calm = (p == 7) || (p == 8);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (p == 3 && k == 8) stall_asks++;   // receiver blocks, pipe backs up
                if (p == 12 && k == 32) settle();     // sender waits for an empty pipe
                offer_beat(rand_beat(), 1'b0, 1'b0, 1'b0);
            end
        end

        settle();
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/vwet_pkg.sv
rtl/vwet_if.sv
rtl/vwet_lane.sv
rtl/vwet_merge.sv
rtl/vector_window_event_trigger.sv
test/tb.sv
